### rtl/msc_pkg.sv
// Package for the MIPS subset core: opcodes, function codes and the sequencer state.
`timescale 1ns / 1ps
package msc_pkg;

  localparam logic [31:0] ResetPc = 32'h0040_0000;

  typedef enum logic [5:0] {
    OP_SPECIAL = 6'h00,
    OP_J       = 6'h02,
    OP_JAL     = 6'h03,
    OP_BEQ     = 6'h04,
    OP_BNE     = 6'h05,
    OP_ADDIU   = 6'h09,
    OP_SLTI    = 6'h0A,
    OP_SLTIU   = 6'h0B,
    OP_ANDI    = 6'h0C,
    OP_ORI     = 6'h0D,
    OP_LUI     = 6'h0F,
    OP_LW      = 6'h23,
    OP_LBU     = 6'h24,
    OP_LHU     = 6'h25,
    OP_SB      = 6'h28,
    OP_SH      = 6'h29,
    OP_SW      = 6'h2B
  } opcode_e;

  typedef enum logic [5:0] {
    FN_SLL     = 6'h00,
    FN_SRL     = 6'h02,
    FN_SRA     = 6'h03,
    FN_JR      = 6'h08,
    FN_SYSCALL = 6'h0C,
    FN_ADDU    = 6'h21,
    FN_SUBU    = 6'h23,
    FN_AND     = 6'h24,
    FN_OR      = 6'h25,
    FN_NOR     = 6'h27,
    FN_SLT     = 6'h2A,
    FN_SLTU    = 6'h2B
  } funct_e;

  // FETCH: instr word read; REGS: operand read; EXEC: compute, data read issued;
  // MEM: load data back, write-back and store
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_REGS,
    ST_EXEC,
    ST_MEM
  } state_e;

endpackage

### rtl/msc_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module msc_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/mips_subset_core.sv
// MIPS subset core: top level with sequencer, register file and main memory.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries action, load_address and
//   load_data. action 0 preloads one memory word; action 1 runs one instruction.
//   Output channel (out_valid_o / out_stall_i) returns one result per transfer.
//   A preload writes memory at its accept edge and its result is valid in the
//   next cycle. An instruction's result is valid once the sequencer has passed
//   through fetch, register read, execute, then memory access and write-back
//   on one edge. The main memory port is used for fetch, then for the data
//   access; each memory has a registered read. Throughput: one preload per
//   cycle while the output is not stalled; an instruction blocks input until done.
//   The result sits in an output register; a new item is accepted at the edge
//   where the previous result transfers out. While a result is stalled the
//   input stalls too.
//   Reset: PC = 0x00400000, halt flag clear, registers read zero (valid bits
//   per register), main memory contents undefined until preloaded.
//   After a syscall every execute transfer returns zeros with halted = 1.
module mips_subset_core #(
  parameter int MEM_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] load_address_i,
  input  logic [31:0] load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] executed_pc_o,
  output logic [31:0] instruction_word_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        mem_written_o,
  output logic        halted_o
);

  localparam int AW = $clog2(MEM_WORDS);

  msc_pkg::state_e state_q, state_d;

  logic [31:0] pc_q, pc_d;
  logic        halt_q, halt_d;
  logic [31:0] ir_q, ir_d;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [31:0] res_q, res_d;
  logic [4:0]  dest_q, dest_d;
  logic        wr_q, wr_d;
  logic [31:0] ea_q, ea_d;
  logic [31:0] rfv_q;   // per-register valid bits (index 0 never set)

  // output register
  logic        ov_q, ov_d;
  logic [31:0] opc_q, opc_d, oir_q, oir_d, oval_q, oval_d;
  logic        owr_q, owr_d, omw_q, omw_d, ohalt_q, ohalt_d;
  logic [4:0]  oidx_q, oidx_d;

  // memories
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          rfa_we, rfb_we;
  logic [4:0]    rfa_addr, rfb_addr;
  logic [31:0]   rfa_rdata, rfb_rdata;
  logic [4:0]    rs_rd, rt_rd;
  logic [31:0]   wb_val;

  msc_ram #(.Width(32), .Depth(MEM_WORDS)) u_mem (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(mem_wdata), .rdata_o(mem_rdata)
  );
  // two copies of the register file give two read ports
  msc_ram #(.Width(32), .Depth(32)) u_rfa (
    .clk_i, .we_i(rfa_we), .addr_i(rfa_addr), .wdata_i(wb_val), .rdata_o(rfa_rdata)
  );
  msc_ram #(.Width(32), .Depth(32)) u_rfb (
    .clk_i, .we_i(rfb_we), .addr_i(rfb_addr), .wdata_i(wb_val), .rdata_o(rfb_rdata)
  );

  logic out_free, in_acc;
  assign out_free = !ov_q || !out_stall_i;
  // a new item may start only when the sequencer is idle and the result slot frees up
  assign in_stall_o = (state_q != msc_pkg::ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // decode fields of the held instruction
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] se, npc, jtgt, btgt, zimm;
  assign op   = ir_q[31:26];
  assign rs   = ir_q[25:21];
  assign rt   = ir_q[20:16];
  assign rd   = ir_q[15:11];
  assign sh   = ir_q[10:6];
  assign fn   = ir_q[5:0];
  assign imm  = ir_q[15:0];
  assign se   = {{16{imm[15]}}, imm};
  assign zimm = {16'h0, imm};
  assign npc  = pc_q + 32'd4;
  assign jtgt = {npc[31:28], ir_q[25:0], 2'b00};
  assign btgt = npc + {se[29:0], 2'b00};

  assign rs_rd = mem_rdata[25:21];
  assign rt_rd = mem_rdata[20:16];

  // store lane merge
  logic [31:0] st_mask, st_data;
  logic [4:0]  st_sh;
  always_comb begin
    st_mask = 32'h0;
    st_data = 32'h0;
    st_sh   = {ea_q[1:0], 3'b000};
    case (op)
      msc_pkg::OP_SB: begin
        st_mask = 32'h0000_00FF << st_sh;
        st_data = b_q << st_sh;
      end
      msc_pkg::OP_SH: begin
        st_sh   = {ea_q[1], 4'b0000};
        st_mask = 32'h0000_FFFF << st_sh;
        st_data = b_q << st_sh;
      end
      msc_pkg::OP_SW: begin
        st_mask = 32'hFFFF_FFFF;
        st_data = b_q;
      end
      default: ;
    endcase
  end

  logic is_store, is_load;
  assign is_store = (op == msc_pkg::OP_SB) || (op == msc_pkg::OP_SH) || (op == msc_pkg::OP_SW);
  assign is_load  = (op == msc_pkg::OP_LBU) || (op == msc_pkg::OP_LHU) || (op == msc_pkg::OP_LW);

  logic [31:0] ld_val;
  always_comb begin
    case (op)
      msc_pkg::OP_LBU: ld_val = {24'h0, 8'(mem_rdata >> {ea_q[1:0], 3'b000})};
      msc_pkg::OP_LHU: ld_val = {16'h0, 16'(mem_rdata >> {ea_q[1], 4'b0000})};
      default:         ld_val = mem_rdata;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;  halt_d = halt_q;  ir_d = ir_q;
    a_d = a_q;  b_d = b_q;  res_d = res_q;  dest_d = dest_q;  wr_d = wr_q;  ea_d = ea_q;
    ov_d = ov_q && out_stall_i;
    opc_d = opc_q;  oir_d = oir_q;  owr_d = owr_q;  oidx_d = oidx_q;
    oval_d = oval_q;  omw_d = omw_q;  ohalt_d = ohalt_q;
    mem_we = 1'b0;
    mem_addr = pc_q[AW+1:2];
    mem_wdata = load_data_i;
    rfa_we = 1'b0;  rfb_we = 1'b0;
    rfa_addr = rs_rd;  rfb_addr = rt_rd;

    case (state_q)
      msc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!action_i) begin
            mem_we = 1'b1;
            mem_addr = load_address_i[AW+1:2];
            ov_d = 1'b1;
            opc_d = '0;  oir_d = '0;  owr_d = 1'b0;  oidx_d = '0;  oval_d = '0;
            omw_d = 1'b0;  ohalt_d = halt_q;
          end else if (halt_q) begin
            ov_d = 1'b1;
            opc_d = '0;  oir_d = '0;  owr_d = 1'b0;  oidx_d = '0;  oval_d = '0;
            omw_d = 1'b0;  ohalt_d = 1'b1;
          end else begin
            state_d = msc_pkg::ST_FETCH;   // memory reads the instruction word
          end
        end
      end
      msc_pkg::ST_FETCH: begin
        ir_d = mem_rdata;                  // register file read issued now
        state_d = msc_pkg::ST_REGS;
      end
      msc_pkg::ST_REGS: begin
        a_d = rfv_q[rs] ? rfa_rdata : 32'h0;
        b_d = rfv_q[rt] ? rfb_rdata : 32'h0;
        state_d = msc_pkg::ST_EXEC;
      end
      msc_pkg::ST_EXEC: begin
        ea_d = a_q + se;
        mem_addr = ea_d[AW+1:2];           // data read for loads and store merge
        wr_d = 1'b0;
        dest_d = rt;
        res_d = '0;
        pc_d = npc;
        if (op == msc_pkg::OP_SPECIAL) begin
          dest_d = rd;
          wr_d = 1'b1;
          case (fn)
            msc_pkg::FN_ADDU: res_d = a_q + b_q;
            msc_pkg::FN_SUBU: res_d = a_q - b_q;
            msc_pkg::FN_AND:  res_d = a_q & b_q;
            msc_pkg::FN_OR:   res_d = a_q | b_q;
            msc_pkg::FN_NOR:  res_d = ~(a_q | b_q);
            msc_pkg::FN_SLL:  res_d = b_q << sh;
            msc_pkg::FN_SRL:  res_d = b_q >> sh;
            msc_pkg::FN_SRA:  res_d = 32'($signed(b_q) >>> sh);
            msc_pkg::FN_SLT:  res_d = {31'h0, $signed(a_q) < $signed(b_q)};
            msc_pkg::FN_SLTU: res_d = {31'h0, a_q < b_q};
            msc_pkg::FN_JR: begin
              wr_d = 1'b0;
              pc_d = a_q;
            end
            msc_pkg::FN_SYSCALL: begin
              wr_d = 1'b0;
              halt_d = 1'b1;
            end
            default: wr_d = 1'b0;
          endcase
        end else begin
          case (op)
            msc_pkg::OP_ADDIU: begin wr_d = 1'b1; res_d = a_q + se; end
            msc_pkg::OP_ANDI:  begin wr_d = 1'b1; res_d = a_q & zimm; end
            msc_pkg::OP_ORI:   begin wr_d = 1'b1; res_d = a_q | zimm; end
            msc_pkg::OP_SLTI:  begin wr_d = 1'b1; res_d = {31'h0, $signed(a_q) < $signed(se)}; end
            msc_pkg::OP_SLTIU: begin wr_d = 1'b1; res_d = {31'h0, a_q < se}; end
            msc_pkg::OP_LUI:   begin wr_d = 1'b1; res_d = {imm, 16'h0}; end
            msc_pkg::OP_BEQ:   if (a_q == b_q) pc_d = btgt;
            msc_pkg::OP_BNE:   if (a_q != b_q) pc_d = btgt;
            msc_pkg::OP_J:     pc_d = jtgt;
            msc_pkg::OP_JAL: begin
              wr_d = 1'b1;
              dest_d = 5'd31;
              res_d = npc + 32'd4;
              pc_d = jtgt;
            end
            msc_pkg::OP_LBU, msc_pkg::OP_LHU, msc_pkg::OP_LW: wr_d = 1'b1;
            default: ;
          endcase
        end
        state_d = msc_pkg::ST_MEM;
      end
      msc_pkg::ST_MEM: begin
        // pc_q already holds the next PC; report the saved one
        mem_addr = ea_q[AW+1:2];
        if (is_store) begin
          mem_we = 1'b1;
          mem_wdata = (mem_rdata & ~st_mask) | (st_data & st_mask);
        end
        if (is_load) res_d = ld_val;
        rfa_we = wr_q && (dest_q != 5'd0);
        rfb_we = rfa_we;
        rfa_addr = dest_q;  rfb_addr = dest_q;
        ov_d = 1'b1;
        opc_d = opc_q;
        oir_d = ir_q;
        owr_d = rfa_we;
        oidx_d = rfa_we ? dest_q : 5'd0;
        oval_d = rfa_we ? (is_load ? ld_val : res_q) : 32'h0;
        omw_d = is_store;
        ohalt_d = halt_q;
        state_d = msc_pkg::ST_IDLE;
      end
      default: state_d = msc_pkg::ST_IDLE;
    endcase
    // latch executed PC at accept of an execute transfer
    if (state_q == msc_pkg::ST_IDLE && in_acc && action_i && !halt_q) opc_d = pc_q;
  end

  // register write data must reflect a load result in the write-back cycle
  assign wb_val = is_load ? ld_val : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msc_pkg::ST_IDLE;
      pc_q    <= msc_pkg::ResetPc;
      halt_q  <= 1'b0;
      rfv_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      ov_q    <= ov_d;
      if (rfa_we) rfv_q[dest_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ir_q <= ir_d;  a_q <= a_d;  b_q <= b_d;  dest_q <= dest_d;  wr_q <= wr_d;  ea_q <= ea_d;
    res_q <= res_d;
    opc_q <= opc_d;  oir_q <= oir_d;  owr_q <= owr_d;  oidx_q <= oidx_d;
    oval_q <= oval_d;  omw_q <= omw_d;  ohalt_q <= ohalt_d;
  end

  assign out_valid_o        = ov_q;
  assign executed_pc_o      = opc_q;
  assign instruction_word_o = oir_q;
  assign reg_written_o      = owr_q;
  assign reg_index_o        = oidx_q;
  assign reg_value_o        = oval_q;
  assign mem_written_o      = omw_q;
  assign halted_o           = ohalt_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != msc_pkg::ST_IDLE) |-> in_stall_o)
    else $error("input accepted while an instruction is in flight");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(reg_value_o)))
    else $error("stalled result changed");
  a_r0_never_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_written_o |-> reg_index_o != 5'd0)
    else $error("register zero reported as written");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");
`endif

endmodule
